// File: design/c3s_pkg.sv
// ----------------------------------------------------------------------------
// c3s_pkg: shared types and constants for the 3x3 smoothing unit
// Geometry limits, payload types, kernel storage types and register indexes.
// ----------------------------------------------------------------------------
package c3s_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int ROW_W      = 10;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int KERN_W     = 3 * COEF_W;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int SUM_W      = 28;
    localparam int CFG_IDX_W  = 3;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // Index 0 is the top row of the window, 2 the bottom row.
    typedef t_pix  [2:0] t_col;
    typedef t_coef [2:0] t_coef_col;

    typedef struct packed {
        t_pix two_above;
        t_pix above;
    } t_lb_word;

    typedef struct packed {
        logic shift;
        logic clear;
        logic ld_prod;
        logic ld_sum;
    } t_cell_ctl;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             emit0;
        logic             emit1;
        logic             frame_end;
    } t_res_ctl;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH       = 3'd0,
        CFG_HEIGHT      = 3'd1,
        CFG_KERN_TOP    = 3'd2,
        CFG_KERN_MIDDLE = 3'd3,
        CFG_KERN_BOTTOM = 3'd4,
        CFG_DROP_TOP    = 3'd5,
        CFG_DROP_BOTTOM = 3'd6
    } t_cfg_reg;

endpackage

// File: design/c3s_if.sv
// ----------------------------------------------------------------------------
// c3s interfaces: pixel input, result output and configuration write channels
// Each channel carries valid, ready and its payload.
// ----------------------------------------------------------------------------
interface c3s_in_if
    import c3s_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       req_type;
    t_pix       pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

interface c3s_out_if
    import c3s_pkg::*;
();
    logic             valid;
    logic             ready;
    t_sum             smoothed;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             run_last;
    logic             frame_last;

    modport source (output valid, output smoothed, output out_row, output out_col,
                    output run_last, output frame_last, input ready);
    modport sink   (input valid, input smoothed, input out_row, input out_col,
                    input run_last, input frame_last, output ready);
endinterface

interface c3s_cfg_if
    import c3s_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [KERN_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/c3s_linebuf.sv
// ----------------------------------------------------------------------------
// c3s_linebuf: two-row line buffer
// One word per column holds the samples of the two previous rows. The read
// data is registered; a write to the address being read is forwarded.
// ----------------------------------------------------------------------------
module c3s_linebuf
    import c3s_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  t_lb_word         i_wr_data,
    output t_lb_word         o_rd_data
);

    t_lb_word r_mem [MAX_WIDTH];
    t_lb_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/c3s_cell.sv
// ----------------------------------------------------------------------------
// c3s_cell: one column of the 3x3 window
// Holds three samples, hands them to its left neighbor on each shift, and
// forms the weighted column sums for the two kernel positions it serves.
// ----------------------------------------------------------------------------
module c3s_cell
    import c3s_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_col      i_col,
    input  t_coef_col i_coef_a,
    input  t_coef_col i_coef_b,
    output t_col      o_col,
    output t_sum      o_sum_a,
    output t_sum      o_sum_b
);

    t_col  r_col;
    t_prod r_prod_a [3];
    t_prod r_prod_b [3];
    t_sum  r_sum_a;
    t_sum  r_sum_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_col <= i_ctl.clear ? '0 : i_col;
        end
        if (i_ctl.ld_prod) begin
            for (int k = 0; k < 3; k++) begin
                r_prod_a[k] <= $signed(i_coef_a[k]) * $signed({1'b0, r_col[k]});
                r_prod_b[k] <= $signed(i_coef_b[k]) * $signed({1'b0, r_col[k]});
            end
        end
        if (i_ctl.ld_sum) begin
            r_sum_a <= t_sum'(r_prod_a[0]) + t_sum'(r_prod_a[1]) + t_sum'(r_prod_a[2]);
            r_sum_b <= t_sum'(r_prod_b[0]) + t_sum'(r_prod_b[1]) + t_sum'(r_prod_b[2]);
        end
    end

    assign o_col   = r_col;
    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;

endmodule

// File: design/conv3x3_zero_pad_smoother_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_smoother_unit: 3x3 zero-padded convolution over a raster
// Line buffer, a chain of three window cells and an output stage that
// issues up to two results per item.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the result side is ready; an item at
// the end of a row can give two results, and the single output register stops
// new items until the first of them is taken.
// Reset: clears the position, the pipeline and the configuration to defaults.
// The line buffer is not cleared; row 0 ignores it, row 1 uses what row 0 wrote.
module conv3x3_zero_pad_smoother_unit
    import c3s_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    c3s_cfg_if.sink      i_cfg,
    c3s_in_if.sink       i_in,
    c3s_out_if.source    o_out
);

    // Configuration
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [KERN_W-1:0] r_kern [3];
    logic              r_drop_top;
    logic              r_drop_bottom;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= DIM_W'(MAX_WIDTH);
            r_height      <= DIM_W'(MAX_HEIGHT);
            r_kern[0]     <= '0;
            r_kern[1]     <= KERN_W'(48'h0000_1000_0000);
            r_kern[2]     <= '0;
            r_drop_top    <= 1'b0;
            r_drop_bottom <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_WIDTH:       r_width       <= i_cfg.data[DIM_W-1:0];
                CFG_HEIGHT:      r_height      <= i_cfg.data[DIM_W-1:0];
                CFG_KERN_TOP:    r_kern[0]     <= i_cfg.data;
                CFG_KERN_MIDDLE: r_kern[1]     <= i_cfg.data;
                CFG_KERN_BOTTOM: r_kern[2]     <= i_cfg.data;
                CFG_DROP_TOP:    r_drop_top    <= i_cfg.data[0];
                CFG_DROP_BOTTOM: r_drop_bottom <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Effective geometry: zero acts as one, anything above the maximum acts as the maximum.
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [COL_W-1:0] w_m1;
    logic signed [DIM_W+1:0] last_row;

    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign w_m1     = COL_W'(w_eff - DIM_W'(1));
    assign last_row = $signed({2'b00, h_eff}) - (DIM_W+2)'(1)
                      - $signed({(DIM_W+1)'(0), r_drop_bottom});

    // Stage enables: a stage loads when it is empty or its content moves on.
    logic en1, en2, en3, en4, en5;
    logic r1_v, r2_v, r3_v, r4_v;
    logic r_pend0, r_pend1;
    logic in_acc, out_acc;

    assign out_acc = o_out.valid && o_out.ready;
    assign en5     = !(r_pend0 || r_pend1) || (o_out.ready && !(r_pend0 && r_pend1));
    assign en4     = !r4_v || en5;
    assign en3     = !r3_v || en4;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign i_in.ready = en1;
    assign in_acc  = i_in.valid && en1;

    // Position of the incoming item
    logic [DIM_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [DIM_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] out_row;
    logic             drain;
    t_pix             sample;
    logic             keep;
    t_res_ctl         res_ctl;

    always_comb begin
        cur_row = (r_in_row > h_eff) ? h_eff : r_in_row;
        cur_col = (r_in_col > w_m1) ? w_m1 : r_in_col;
        drain   = i_in.req_type || (cur_row >= h_eff);
        sample  = drain ? '0 : i_in.pixel;
        out_row = ROW_W'(cur_row - DIM_W'(1));
        keep    = (cur_row != '0)
                  && !(r_drop_top && (out_row == '0))
                  && ($signed({(DIM_W+2-ROW_W)'(0), out_row}) <= last_row);
        res_ctl.row       = out_row;
        res_ctl.col       = cur_col;
        res_ctl.emit0     = keep && (cur_col != '0);
        res_ctl.emit1     = keep && (cur_col == w_m1);
        res_ctl.frame_end = $signed({(DIM_W+2-ROW_W)'(0), out_row}) == last_row;
        if (cur_col == w_m1) begin
            n_in_col = '0;
            n_in_row = (cur_row >= h_eff) ? '0 : cur_row + DIM_W'(1);
        end else begin
            n_in_col = cur_col + COL_W'(1);
            n_in_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
        end else if (in_acc) begin
            r_in_row <= n_in_row;
            r_in_col <= n_in_col;
        end
    end

    // Stage 1: line buffer read data arrives; the buffer entry is rewritten once.
    logic             r1_wr;
    logic [COL_W-1:0] r1_c;
    t_pix             r1_s;
    logic             r1_has_top;
    logic             r1_has_mid;
    t_res_ctl         r1_ctl;
    t_lb_word         lb_rd;
    t_lb_word         lb_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r1_wr <= 1'b0;
        end else begin
            r1_wr <= in_acc;
            if (en1) begin
                r1_v <= in_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_c       <= cur_col;
            r1_s       <= sample;
            r1_has_top <= cur_row >= DIM_W'(2);
            r1_has_mid <= cur_row >= DIM_W'(1);
            r1_ctl     <= res_ctl;
        end
    end

    assign lb_wr.two_above = lb_rd.above;
    assign lb_wr.above     = r1_s;

    c3s_linebuf u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (cur_col),
        .i_wr_en   (r1_wr),
        .i_wr_addr (r1_c),
        .i_wr_data (lb_wr),
        .o_rd_data (lb_rd)
    );

    // Stages 2 to 4 live in the cell chain: window, products, column sums.
    t_col      new_col;
    t_col      cell_col [3];
    t_sum      sum_a [3];
    t_sum      sum_b [3];
    t_coef_col coef [3];
    t_cell_ctl cell_ctl;

    assign new_col[0] = r1_has_top ? lb_rd.two_above : '0;
    assign new_col[1] = r1_has_mid ? lb_rd.above : '0;
    assign new_col[2] = r1_s;

    assign cell_ctl.shift   = en2 && r1_v;
    assign cell_ctl.clear   = r1_c == '0;
    assign cell_ctl.ld_prod = en3;
    assign cell_ctl.ld_sum  = en4;

    // Coefficient column j: left tap in the high bits of each kernel row.
    for (genvar j = 0; j < 3; j++) begin : g_coef
        for (genvar k = 0; k < 3; k++) begin : g_row
            assign coef[j][k] = r_kern[k][KERN_W-1-COEF_W*j -: COEF_W];
        end
    end

    for (genvar t = 0; t < 3; t++) begin : g_cell
        t_cell_ctl ctl_t;
        t_col      in_t;
        t_coef_col coef_b_t;

        always_comb begin
            ctl_t = cell_ctl;
            if (t == 2) begin
                ctl_t.clear = 1'b0;
            end
        end

        if (t == 2) begin : g_head
            assign in_t = new_col;
        end else begin : g_body
            assign in_t = cell_col[t+1];
        end

        // The right-edge result sees this column one tap further left;
        // the leftmost column falls outside its window.
        if (t == 0) begin : g_no_b
            assign coef_b_t = '0;
        end else begin : g_b
            assign coef_b_t = coef[t-1];
        end

        c3s_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl_t),
            .i_col    (in_t),
            .i_coef_a (coef[t]),
            .i_coef_b (coef_b_t),
            .o_col    (cell_col[t]),
            .o_sum_a  (sum_a[t]),
            .o_sum_b  (sum_b[t])
        );
    end

    t_res_ctl r2_ctl, r3_ctl, r4_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) r2_ctl <= r1_ctl;
        if (en3) r3_ctl <= r2_ctl;
        if (en4) r4_ctl <= r3_ctl;
    end

    // Stage 5: output register holding both results of one item.
    t_sum             r_sum0, r_sum1;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;
    logic             r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend0 <= 1'b0;
            r_pend1 <= 1'b0;
        end else if (en5) begin
            r_pend0 <= r4_v && r4_ctl.emit0;
            r_pend1 <= r4_v && r4_ctl.emit1;
        end else if (out_acc) begin
            r_pend0 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_sum0      <= sum_a[0] + sum_a[1] + sum_a[2];
            r_sum1      <= sum_b[0] + sum_b[1] + sum_b[2];
            r_out_row   <= r4_ctl.row;
            r_out_col   <= r4_ctl.col;
            r_frame_end <= r4_ctl.frame_end;
        end
    end

    assign o_out.valid      = r_pend0 || r_pend1;
    assign o_out.smoothed   = r_pend0 ? r_sum0 : r_sum1;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_pend0 ? r_out_col - COL_W'(1) : r_out_col;
    assign o_out.run_last   = !(r_pend0 && r_pend1);
    assign o_out.frame_last = !r_pend0 && r_frame_end;

    // A result that is not the last of its item is followed by another.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.run_last |=> o_out.valid)
        else $error("result run ended early");

    a_frame_last_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_last |-> o_out.run_last)
        else $error("frame end not on last result of its item");

    a_wr_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_wr |-> r1_v)
        else $error("line buffer write without an item in stage 1");

    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_pend0 || r_pend1))
        else $error("input stalled while output register is empty");

endmodule

// File: sim/conv3x3_zero_pad_smoother_unit_test.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_smoother_unit_test: self-checking bench for the smoother
// Streams whole frames through the unit and predicts every result in the
// bench itself. A short table of frames comes first, with some results typed
// in by hand. Random frames follow, with random geometry, kernels and halo
// flags, then one frame at the largest width and one at the largest height.
// Both sides of the stream idle at random, and the result side holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_smoother_unit_test;
    import c3s_pkg::*;

    localparam int     NUM_REGS       = 7;
    localparam int     RESULT_LATENCY = 5;
    localparam int     DIR_ROWS       = 20;
    localparam int     RANDOM_ITEMS   = 1000;
    localparam int     HOLD_AT        = 150;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     STALL_LIMIT    = 2000;
    localparam longint SUM_HI         = 134217727;
    localparam longint SUM_LO         = -134217728;

    localparam logic [NUM_REGS-1:0] GEOM_REGS = 7'd1 << CFG_WIDTH | 7'd1 << CFG_HEIGHT;
    localparam logic [NUM_REGS-1:0] DROP_REGS = 7'd1 << CFG_DROP_TOP | 7'd1 << CFG_DROP_BOTTOM;
    localparam logic [NUM_REGS-1:0] ALL_REGS  = '1;

    typedef struct packed {
        t_sum             smoothed;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             run_last;
        logic             frame_last;
    } t_smooth_res;

    typedef struct packed {
        logic        drain;
        t_pix        px;
        logic        typed;
        logic [1:0]  n_typed;
        t_smooth_res res_a;
        t_smooth_res res_b;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    c3s_in_if  pix_ch ();
    c3s_out_if res_ch ();
    c3s_cfg_if cfg_ch ();

    conv3x3_zero_pad_smoother_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (pix_ch),
        .o_out   (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Configuration as the predictor sees it.
    logic [DIM_W-1:0]  cfg_width;
    logic [DIM_W-1:0]  cfg_height;
    logic [KERN_W-1:0] cfg_kern [3];
    logic              cfg_drop_top;
    logic              cfg_drop_bottom;

    // Predictor state: line stores, 3x3 window and raster position.
    t_pix        above_line     [MAX_WIDTH];
    t_pix        two_above_line [MAX_WIDTH];
    t_pix        win [3][3];
    int unsigned at_row;
    int unsigned at_col;
    t_smooth_res step_res [2];
    int          step_n;

    t_smooth_res       awaited [$];
    logic [KERN_W-1:0] setup_val [NUM_REGS];
    t_dir_row          dir_rows [DIR_ROWS];
    int unsigned       items_sent = 0;
    int unsigned       mismatches = 0;
    int unsigned       quiet_cycles = 0;
    bit                src_calm = 1'b0;

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // Weighted sum for the centre in window column centre; column 3 is padding.
    function automatic t_sum window_total(int unsigned centre);
        longint      acc;
        longint      tap;
        t_coef       coef;
        int unsigned t;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                t = centre - 1 + j;
                tap = (t < 3) ? longint'(win[k][t]) : 0;
                coef = cfg_kern[k][(2 - j) * COEF_W +: COEF_W];
                acc += longint'(coef) * tap;
            end
        end
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        return t_sum'(acc);
    endfunction

    function automatic void note_result(int unsigned col, int unsigned o, t_sum v, logic fl);
        step_res[step_n] = '{smoothed: v, row: o[ROW_W-1:0], col: col[COL_W-1:0],
                             run_last: 1'b0, frame_last: fl};
        step_n++;
    endfunction

    function automatic t_smooth_res unit_res(t_pix p, int row, int col, logic rl, logic fl);
        return '{smoothed: t_sum'(int'(p) * 4096), row: row[ROW_W-1:0],
                 col: col[COL_W-1:0], run_last: rl, frame_last: fl};
    endfunction

    task automatic smooth_step(input logic drain_req, input t_pix px);
        int unsigned w, h, r, c, o;
        int          last;
        t_pix        s, top, mid;
        w = eff_dim(cfg_width, MAX_WIDTH);
        h = eff_dim(cfg_height, MAX_HEIGHT);
        r = (at_row > h) ? h : at_row;
        c = (at_col > w - 1) ? w - 1 : at_col;
        s = (drain_req || r >= h) ? '0 : px;
        top = (r >= 2) ? two_above_line[c] : '0;
        mid = (r >= 1) ? above_line[c] : '0;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = (c == 0) ? '0 : win[k][1];
            win[k][1] = (c == 0) ? '0 : win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = s;
        two_above_line[c] = above_line[c];
        above_line[c] = s;
        step_n = 0;
        last = int'(h) - 1 - int'(cfg_drop_bottom);
        if (r >= 1) begin
            o = r - 1;
            if (o >= cfg_drop_top && int'(o) <= last) begin
                // The left neighbor of the current column is never the last column.
                if (c >= 1) note_result(c - 1, o, window_total(1), 1'b0);
                if (c == w - 1) note_result(c, o, window_total(2), int'(o) == last);
            end
        end
        if (step_n > 0) step_res[step_n - 1].run_last = 1'b1;
        if (c == w - 1) begin
            at_col = 0;
            at_row = (r >= h) ? 0 : r + 1;
        end else begin
            at_col = c + 1;
            at_row = r;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 50)
            $display("mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
        mismatches++;
    endtask

    // Writes the registers picked by mask from setup_val, keeping valid high
    // across back-to-back writes.
    task automatic load_setup(input logic [NUM_REGS-1:0] mask);
        t_cfg_reg idx;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (mask[i]) begin
                idx = t_cfg_reg'(i);
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= idx;
                cfg_ch.data  <= setup_val[i];
                @(posedge i_clk);
                while (!cfg_ch.ready) @(posedge i_clk);
                case (idx)
                    CFG_WIDTH:       cfg_width = setup_val[i][DIM_W-1:0];
                    CFG_HEIGHT:      cfg_height = setup_val[i][DIM_W-1:0];
                    CFG_KERN_TOP:    cfg_kern[0] = setup_val[i];
                    CFG_KERN_MIDDLE: cfg_kern[1] = setup_val[i];
                    CFG_KERN_BOTTOM: cfg_kern[2] = setup_val[i];
                    CFG_DROP_TOP:    cfg_drop_top = setup_val[i][0];
                    CFG_DROP_BOTTOM: cfg_drop_bottom = setup_val[i][0];
                    default: ;
                endcase
            end
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(input logic drain_req, input t_pix px, input logic typed,
                             input int n_typed, input t_smooth_res typed_a,
                             input t_smooth_res typed_b);
        int unsigned gap;
        if ($urandom_range(39) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(17);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.req_type <= drain_req;
        pix_ch.pixel    <= px;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        smooth_step(drain_req, px);
        if (typed) begin
            if (n_typed > 0) awaited.push_back(typed_a);
            if (n_typed > 1) awaited.push_back(typed_b);
        end else begin
            for (int i = 0; i < step_n; i++) awaited.push_back(step_res[i]);
        end
        items_sent++;
    endtask

    task automatic walk_rows(input int lo, input int hi);
        for (int i = lo; i <= hi; i++)
            send_item(dir_rows[i].drain, dir_rows[i].px, dir_rows[i].typed,
                      dir_rows[i].n_typed, dir_rows[i].res_a, dir_rows[i].res_b);
    endtask

    // One frame: H image rows, then the drain row. A few drain items land
    // inside the image and a few pixel items land in the drain row.
    task automatic send_frame();
        int unsigned w, h;
        logic        drain_req;
        w = eff_dim(cfg_width, MAX_WIDTH);
        h = eff_dim(cfg_height, MAX_HEIGHT);
        for (int unsigned r = 0; r <= h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                drain_req = (r < h) ? ($urandom_range(11) == 0) : ($urandom_range(5) != 0);
                send_item(drain_req, t_pix'($urandom_range(255)), 1'b0, 0, '0, '0);
            end
        end
    endtask

    // Waits until every awaited result is in, then lets items with no
    // results drain out of the pipeline.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n         = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.req_type = 1'b0;
        pix_ch.pixel    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;

        cfg_width       = DIM_W'(MAX_WIDTH);
        cfg_height      = DIM_W'(MAX_HEIGHT);
        cfg_kern[0]     = '0;
        cfg_kern[1]     = 48'h0000_1000_0000;
        cfg_kern[2]     = '0;
        cfg_drop_top    = 1'b0;
        cfg_drop_bottom = 1'b0;
        at_row          = 0;
        at_col          = 0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            above_line[i]     = '0;
            two_above_line[i] = '0;
        end
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++) win[k][j] = '0;

        // 3x2 frame under the reset kernel, which passes the centre through
        // scaled by 4096. Row 1 column 1 is a drain item inside the image;
        // the drain row carries one pixel item whose value must be ignored.
        dir_rows[0]  = '{1'b0, 8'd255, 1'b1, 2'd0, '0, '0};
        dir_rows[1]  = '{1'b0, 8'd0,   1'b1, 2'd0, '0, '0};
        dir_rows[2]  = '{1'b0, 8'd17,  1'b1, 2'd0, '0, '0};
        dir_rows[3]  = '{1'b0, 8'd128, 1'b1, 2'd0, '0, '0};
        dir_rows[4]  = '{1'b1, 8'h5A,  1'b1, 2'd1, unit_res(8'd255, 0, 0, 1'b1, 1'b0), '0};
        dir_rows[5]  = '{1'b0, 8'd1,   1'b1, 2'd2, unit_res(8'd0, 0, 1, 1'b0, 1'b0),
                         unit_res(8'd17, 0, 2, 1'b1, 1'b0)};
        dir_rows[6]  = '{1'b1, 8'd0,   1'b1, 2'd0, '0, '0};
        dir_rows[7]  = '{1'b0, 8'hAA,  1'b1, 2'd1, unit_res(8'd128, 1, 0, 1'b1, 1'b0), '0};
        dir_rows[8]  = '{1'b1, 8'hFF,  1'b1, 2'd2, unit_res(8'd0, 1, 1, 1'b0, 1'b0),
                         unit_res(8'd1, 1, 2, 1'b1, 1'b1)};
        // 2x3 frame with extreme coefficients and the top row dropped.
        dir_rows[9]  = '{1'b0, 8'd255, 1'b0, 2'd0, '0, '0};
        dir_rows[10] = '{1'b0, 8'd255, 1'b0, 2'd0, '0, '0};
        dir_rows[11] = '{1'b0, 8'd0,   1'b0, 2'd0, '0, '0};
        dir_rows[12] = '{1'b0, 8'd255, 1'b0, 2'd0, '0, '0};
        dir_rows[13] = '{1'b0, 8'd255, 1'b0, 2'd0, '0, '0};
        dir_rows[14] = '{1'b0, 8'd0,   1'b0, 2'd0, '0, '0};
        dir_rows[15] = '{1'b1, 8'd255, 1'b0, 2'd0, '0, '0};
        dir_rows[16] = '{1'b1, 8'd255, 1'b0, 2'd0, '0, '0};
        // 1x2 frame with both halo rows dropped keeps nothing.
        dir_rows[17] = '{1'b0, 8'd255, 1'b1, 2'd0, '0, '0};
        dir_rows[18] = '{1'b0, 8'd0,   1'b1, 2'd0, '0, '0};
        dir_rows[19] = '{1'b1, 8'd0,   1'b1, 2'd0, '0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        setup_val[CFG_WIDTH]  = KERN_W'(3);
        setup_val[CFG_HEIGHT] = KERN_W'(2);
        load_setup(GEOM_REGS);
        walk_rows(0, 8);

        settle();
        setup_val[CFG_WIDTH]       = KERN_W'(2);
        setup_val[CFG_HEIGHT]      = KERN_W'(3);
        setup_val[CFG_KERN_TOP]    = {16'h7FFF, 16'h8000, 16'h7FFF};
        setup_val[CFG_KERN_MIDDLE] = {16'h8000, 16'h7FFF, 16'h8000};
        setup_val[CFG_KERN_BOTTOM] = {16'hFFFF, 16'h0001, 16'h0000};
        setup_val[CFG_DROP_TOP]    = KERN_W'(1);
        setup_val[CFG_DROP_BOTTOM] = KERN_W'(0);
        load_setup(ALL_REGS);
        walk_rows(9, 16);

        settle();
        setup_val[CFG_WIDTH]       = KERN_W'(1);
        setup_val[CFG_HEIGHT]      = KERN_W'(2);
        setup_val[CFG_DROP_BOTTOM] = KERN_W'(1);
        load_setup(GEOM_REGS | DROP_REGS);
        walk_rows(17, 19);

        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(2) != 0) begin
                settle();
                case ($urandom_range(9))
                    0:       setup_val[CFG_WIDTH] = '0;
                    1:       setup_val[CFG_WIDTH] = KERN_W'($urandom_range(24, 9));
                    default: setup_val[CFG_WIDTH] = KERN_W'($urandom_range(8, 1));
                endcase
                setup_val[CFG_HEIGHT] = ($urandom_range(7) == 0) ? '0
                                        : KERN_W'($urandom_range(6, 1));
                for (int k = 0; k < 3; k++)
                    setup_val[int'(CFG_KERN_TOP) + k] = ($urandom_range(5) == 0)
                        ? {3{16'h8000}} : KERN_W'({$urandom, $urandom});
                setup_val[CFG_DROP_TOP]    = KERN_W'($urandom_range(1));
                setup_val[CFG_DROP_BOTTOM] = KERN_W'($urandom_range(1));
                load_setup(GEOM_REGS | NUM_REGS'($urandom));
            end
            send_frame();
        end

        // Widest single-row frame, then the tallest single-column frame.
        settle();
        setup_val[CFG_WIDTH]       = KERN_W'(2047);
        setup_val[CFG_HEIGHT]      = '0;
        setup_val[CFG_KERN_TOP]    = KERN_W'({$urandom, $urandom});
        setup_val[CFG_KERN_MIDDLE] = KERN_W'({$urandom, $urandom});
        setup_val[CFG_KERN_BOTTOM] = KERN_W'({$urandom, $urandom});
        setup_val[CFG_DROP_TOP]    = '0;
        setup_val[CFG_DROP_BOTTOM] = '0;
        load_setup(ALL_REGS);
        send_frame();

        settle();
        setup_val[CFG_WIDTH]       = '0;
        setup_val[CFG_HEIGHT]      = KERN_W'(2047);
        setup_val[CFG_DROP_TOP]    = KERN_W'(1);
        setup_val[CFG_DROP_BOTTOM] = KERN_W'(1);
        load_setup(GEOM_REGS | DROP_REGS);
        send_frame();

        settle();
        if (mismatches == 0)
            $display("PASS conv3x3_zero_pad_smoother_unit");
        else
            $display("FAIL conv3x3_zero_pad_smoother_unit");
        $finish;
    end

    initial begin : result_sink
        int unsigned gap;
        int unsigned taken;
        bit          sink_calm;
        t_smooth_res want;
        taken = 0;
        sink_calm = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(39) == 0) sink_calm = !sink_calm;
            gap = sink_calm ? 0 : $urandom_range(17);
            // One long hold-off so the unit fills up and stalls its input.
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            taken++;
            if (awaited.size() == 0) begin
                report_mismatch("result with nothing awaited", longint'(res_ch.smoothed), 0);
            end else begin
                want = awaited.pop_front();
                if (res_ch.smoothed !== want.smoothed)
                    report_mismatch("smoothed", longint'(res_ch.smoothed),
                                    longint'(want.smoothed));
                if (res_ch.out_row !== want.row)
                    report_mismatch("out_row", res_ch.out_row, want.row);
                if (res_ch.out_col !== want.col)
                    report_mismatch("out_col", res_ch.out_col, want.col);
                if (res_ch.run_last !== want.run_last)
                    report_mismatch("run_last", res_ch.run_last, want.run_last);
                if (res_ch.frame_last !== want.frame_last)
                    report_mismatch("frame_last", res_ch.frame_last, want.frame_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL conv3x3_zero_pad_smoother_unit");
            $finish;
        end
    end

endmodule

// File: sim.f
design/c3s_pkg.sv
design/c3s_if.sv
design/c3s_linebuf.sv
design/c3s_cell.sv
design/conv3x3_zero_pad_smoother_unit.sv
sim/conv3x3_zero_pad_smoother_unit_test.sv
